FILE: hdl/fcfa_pkg.sv
// Shared constants and types of the fixed chunk free list allocator.
package fcfa_pkg;

  // Pool capacity in chunks; the port widths below are sized for it
  localparam int MAX_CHUNKS = 1024;

  // Field widths of the ports
  localparam int CNT_W     = 11;
  localparam int IDX_W     = 10;
  localparam int CW_W      = 15;
  localparam int ADDR_W    = 64;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Chunk words are 4 bytes wide
  localparam int WORD_SHIFT = 2;

  // Request commands
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_WORDS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE        = 2'd2;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Occupancy thresholds as integer percentages of the pool
  localparam int DANGER_PCT = 95;
  localparam int SAFE_PCT   = 90;

  // floor(x / 100) as (x * PCT_RECIP) >> PCT_SHIFT, exact for x below 2^18
  localparam int RAW_W     = 18;
  localparam int RECIP_W   = 20;
  localparam int PCT_SHIFT = 26;
  localparam int PCT_RECIP = 671089;

endpackage

FILE: hdl/fcfa_level.sv
// Occupancy level unit: danger and safe thresholds and the danger excess.
module fcfa_level (
  input  logic                        clk,
  input  logic [fcfa_pkg::CNT_W-1:0]  total_chunks,
  input  logic [fcfa_pkg::CNT_W-1:0]  free_count,
  output logic [fcfa_pkg::CNT_W-1:0]  danger_excess
);
  import fcfa_pkg::*;

  localparam int PROD_W = RAW_W + RECIP_W;

  logic [RAW_W-1:0]  danger_raw_r;
  logic [RAW_W-1:0]  safe_raw_r;
  logic [CNT_W-1:0]  danger_lvl_r;
  logic [CNT_W-1:0]  safe_lvl_r;
  logic [PROD_W-1:0] danger_prod;
  logic [PROD_W-1:0] safe_prod;
  logic [CNT_W-1:0]  used;

  // Divide the scaled totals by 100 through the reciprocal
  assign danger_prod = PROD_W'(danger_raw_r) * PROD_W'(PCT_RECIP);
  assign safe_prod   = PROD_W'(safe_raw_r) * PROD_W'(PCT_RECIP);

  // Register the scaled totals, then the danger and safe levels derived from them
  always_ff @(posedge clk) begin
    danger_raw_r <= RAW_W'(total_chunks * DANGER_PCT);
    safe_raw_r   <= RAW_W'(total_chunks * SAFE_PCT);
    danger_lvl_r <= CNT_W'(danger_prod >> PCT_SHIFT);
    safe_lvl_r   <= CNT_W'(safe_prod >> PCT_SHIFT);
  end

  // Report how far use runs past the safe level once above the danger level
  assign used          = total_chunks - free_count;
  assign danger_excess = (used > danger_lvl_r) ? (used - safe_lvl_r) : '0;

endmodule

FILE: hdl/fixed_chunk_free_list_allocator.sv
// Top level of the fixed chunk free list allocator with run-length free list nodes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall   | in_command, in_chunk_index
//  out     | out       | out_valid / out_stall | out_status, out_granted_index,
//          |           |                       | out_granted_address, out_free_count,
//          |           |                       | out_danger_excess
//
// In the accept cycle a request updates the head node and issues the node memory
// access; in S_FIN it takes the node memory read data and fills the result register
// once that register is free. After reset and after each register write, the setup
// states S_INIT and S_THR write node 0 and settle the thresholds; no request is taken
// then. A request is taken while a result waits on out_stall; its own result then
// waits until the result register frees.
module fixed_chunk_free_list_allocator (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcfa_pkg::ADDR_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_command,
  input  logic [fcfa_pkg::IDX_W-1:0]        in_chunk_index,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [fcfa_pkg::STAT_W-1:0]       out_status,
  output logic [fcfa_pkg::IDX_W-1:0]        out_granted_index,
  output logic [fcfa_pkg::ADDR_W-1:0]       out_granted_address,
  output logic [fcfa_pkg::CNT_W-1:0]        out_free_count,
  output logic [fcfa_pkg::CNT_W-1:0]        out_danger_excess
);
  import fcfa_pkg::*;

  localparam int HW     = $clog2(MAX_CHUNKS);
  localparam int LW     = $clog2(MAX_CHUNKS + 1);
  localparam int NODE_W = CNT_W + LW;
  localparam int PROD_W = HW + CW_W;
  localparam logic [LW-1:0]    NULL_LINK = LW'(MAX_CHUNKS);
  localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'((MAX_CHUNKS < 1024) ? MAX_CHUNKS : 1024);

  typedef enum logic [1:0] {
    S_INIT,
    S_THR,
    S_IDLE,
    S_FIN
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CW_W-1:0]    cw_r, cw_nxt;
  logic [ADDR_W-1:0]  base_r, base_nxt;
  logic               head_valid_r, head_valid_nxt;
  logic [HW-1:0]      head_r, head_nxt;
  logic [CNT_W-1:0]   run_r, run_nxt;
  logic [LW-1:0]      link_r, link_nxt;
  logic [CNT_W-1:0]   fc_r, fc_nxt;
  status_t            status_r, status_nxt;
  logic               grant_ok_r, grant_ok_nxt;
  logic [HW-1:0]      grant_idx_r, grant_idx_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic               load_r, load_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]  out_status_r, out_status_nxt;
  logic [IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  logic [CNT_W-1:0]   out_fc_r, out_fc_nxt;
  logic [CNT_W-1:0]   out_excess_r, out_excess_nxt;

  logic               in_take;
  logic               out_take;
  logic               cfg_hit;
  logic [CNT_W-1:0]   total_raw;
  logic [LW-1:0]      new_link;
  logic [CNT_W-1:0]   excess;

  // Node memory: run length over link per chunk
  logic [NODE_W-1:0]  node_mem [MAX_CHUNKS];
  logic               mem_we;
  logic [HW-1:0]      mem_waddr;
  logic [NODE_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [HW-1:0]      mem_raddr;
  logic [NODE_W-1:0]  mem_rdata_r;

  fcfa_level u_level (
    .clk           (clk),
    .total_chunks  (total_r),
    .free_count    (fc_r),
    .danger_excess (excess)
  );

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign cfg_hit   = cfg_valid &&
                     (cfg_index == CFG_TOTAL || cfg_index == CFG_CHUNK_WORDS ||
                      cfg_index == CFG_BASE);
  assign total_raw = cfg_data[CNT_W-1:0];
  assign new_link  = head_valid_r ? LW'(head_r) : NULL_LINK;

  // Next state of the pool, the request in flight and the result register
  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    cw_nxt         = cw_r;
    base_nxt       = base_r;
    head_valid_nxt = head_valid_r;
    head_nxt       = head_r;
    run_nxt        = run_r;
    link_nxt       = link_r;
    fc_nxt         = fc_r;
    status_nxt     = status_r;
    grant_ok_nxt   = grant_ok_r;
    grant_idx_nxt  = grant_idx_r;
    prod_nxt       = prod_r;
    load_nxt       = load_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_addr_nxt   = out_addr_r;
    out_fc_nxt     = out_fc_r;
    out_excess_nxt = out_excess_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    case (state_r)
      // Lay the whole pool out as one run at node 0
      S_INIT: begin
        mem_we         = 1'b1;
        mem_wdata      = {total_r, NULL_LINK};
        head_valid_nxt = 1'b1;
        head_nxt       = '0;
        run_nxt        = total_r;
        link_nxt       = NULL_LINK;
        fc_nxt         = total_r;
        state_nxt      = S_THR;
      end
      // Wait for the thresholds to settle
      S_THR: begin
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_take) begin
          status_nxt    = ST_OK;
          grant_ok_nxt  = 1'b0;
          grant_idx_nxt = head_r;
          load_nxt      = 1'b0;
          prod_nxt      = PROD_W'(head_r) * PROD_W'(cw_r);
          state_nxt     = S_FIN;
          if (in_command == CMD_ALLOC) begin
            if (fc_r == '0 || !head_valid_r) begin
              status_nxt = ST_EMPTY;
            end else begin
              grant_ok_nxt = 1'b1;
              fc_nxt       = fc_r - 1'b1;
              if (run_r > CNT_W'(1) && (int'(head_r) + 1) < MAX_CHUNKS) begin
                // Advance inside the run and store the shortened node
                head_nxt  = head_r + 1'b1;
                run_nxt   = run_r - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = head_r + 1'b1;
                mem_wdata = {run_r - 1'b1, link_r};
              end else if (link_r < NULL_LINK) begin
                // Follow the link; the node arrives next cycle
                head_nxt  = HW'(link_r);
                mem_re    = 1'b1;
                mem_raddr = HW'(link_r);
                load_nxt  = 1'b1;
              end else begin
                head_valid_nxt = 1'b0;
                head_nxt       = '0;
              end
            end
          end else begin
            if ({1'b0, in_chunk_index} >= total_r) begin
              status_nxt = ST_RANGE;
            end else begin
              // Push the chunk as a run of one
              mem_we         = 1'b1;
              mem_waddr      = HW'(in_chunk_index);
              mem_wdata      = {CNT_W'(1), new_link};
              head_nxt       = HW'(in_chunk_index);
              head_valid_nxt = 1'b1;
              run_nxt        = CNT_W'(1);
              link_nxt       = new_link;
              if (fc_r < total_r) begin
                fc_nxt = fc_r + 1'b1;
              end
            end
          end
        end
      end
      S_FIN: begin
        if (load_r) begin
          run_nxt  = mem_rdata_r[NODE_W-1:LW];
          link_nxt = mem_rdata_r[LW-1:0];
        end
        // Fill the result register once it is free
        if (!out_valid_r || out_take) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_idx_nxt    = grant_ok_r ? IDX_W'(grant_idx_r) : '0;
          out_addr_nxt   = grant_ok_r ? (base_r + (ADDR_W'(prod_r) << WORD_SHIFT)) : '0;
          out_fc_nxt     = fc_r;
          out_excess_nxt = excess;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    // Register writes rebuild the pool
    if (cfg_hit) begin
      case (cfg_index)
        CFG_TOTAL: begin
          if (total_raw == '0) begin
            total_nxt = CNT_W'(1);
          end else if (int'(total_raw) > MAX_CHUNKS) begin
            total_nxt = CNT_W'(MAX_CHUNKS);
          end else begin
            total_nxt = total_raw;
          end
        end
        CFG_CHUNK_WORDS: cw_nxt = cfg_data[CW_W-1:0];
        CFG_BASE:        base_nxt = cfg_data;
        default:         total_nxt = total_r;
      endcase
      state_nxt = S_INIT;
    end
  end

  // Hold state, pool registers and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      total_r      <= TOTAL_RST;
      cw_r         <= CW_W'(16);
      base_r       <= '0;
      head_valid_r <= 1'b1;
      head_r       <= '0;
      fc_r         <= TOTAL_RST;
      load_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      total_r      <= total_nxt;
      cw_r         <= cw_nxt;
      base_r       <= base_nxt;
      head_valid_r <= head_valid_nxt;
      head_r       <= head_nxt;
      fc_r         <= fc_nxt;
      load_r       <= load_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    run_r        <= run_nxt;
    link_r       <= link_nxt;
    status_r     <= status_nxt;
    grant_ok_r   <= grant_ok_nxt;
    grant_idx_r  <= grant_idx_nxt;
    prod_r       <= prod_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_addr_r   <= out_addr_nxt;
    out_fc_r     <= out_fc_nxt;
    out_excess_r <= out_excess_nxt;
  end

  // Node memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= node_mem[mem_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_index   = out_idx_r;
  assign out_granted_address = out_addr_r;
  assign out_free_count      = out_fc_r;
  assign out_danger_excess   = out_excess_r;

  // The free count never exceeds the pool once set up
  a_fc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (fc_r <= total_r))
    else $error("free count above pool size");

  // The node memory is left alone while a request waits for its result slot
  a_no_write_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> !mem_we)
    else $error("node memory written during result cycle");

  // A finishing request reaches the result register when it is free
  a_fin_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && !(out_valid_r && out_stall)) |=> out_valid_r)
    else $error("result lost at finish");

endmodule
